/* design/bsmu_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constant tables for the bond-slip material update block.
package bsmu_pkg;

	localparam int FRAC_W  = 24;   // fraction bits of the log2 / exp2 path
	localparam int DIV_W   = 64;   // dividend and quotient width of the divider
	localparam int DVSR_W  = 32;   // divisor width of the divider
	localparam int CNT_W   = 5;    // loop counter of the log2 / exp2 steps

	typedef enum logic [1:0] {
		MODE_TRIAL  = 2'd0,
		MODE_COMMIT = 2'd1,
		MODE_REVERT = 2'd2,
		MODE_RESET  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_PEAK_STRESS  = 3'd0,
		REG_RESID_STRESS = 3'd1,
		REG_LIN_SLIP     = 3'd2,
		REG_PEAK_SLIP    = 3'd3,
		REG_PLAT_SLIP    = 3'd4,
		REG_SOFT_SLIP    = 3'd5,
		REG_EXPONENT     = 3'd6,
		REG_STIFFNESS    = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		RG_LIN,
		RG_POW,
		RG_PLAT,
		RG_SOFT,
		RG_RESID
	} region_t;

	typedef enum logic [5:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_SETUP,
		OP_COMMIT,
		OP_REVERT,
		OP_RESET,
		OP_MUL_LIN,
		OP_LIN_FIN,
		OP_DIV_X,
		OP_POW_ONE,
		OP_NORM_LOAD,
		OP_NORM_SHIFT,
		OP_SQ_MUL,
		OP_SQ_ADJ,
		OP_NL_MUL,
		OP_NY_LATCH,
		OP_EXP_MUL,
		OP_EXP_UPD,
		OP_P_FIN,
		OP_TAU_MUL,
		OP_TAU_FIN,
		OP_TANP_MUL,
		OP_TANP_DIV,
		OP_TANP_FIN,
		OP_PLAT,
		OP_SOFT_MUL,
		OP_SOFT_DIV,
		OP_SOFT_TAU,
		OP_SOFT_DIV2,
		OP_SOFT_FIN,
		OP_RESID,
		OP_UNL_MUL,
		OP_STRESS,
		OP_WORK_MUL,
		OP_WORK_FIN,
		OP_OUT_LOAD
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		mode_t   mode;
		region_t region;
		logic    x_ge_one;
		logic    norm_done;
		logic    div_busy;
	} status_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] slip;
	} in_t;

	typedef struct packed {
		logic signed [31:0] bond_stress;
		logic signed [31:0] tangent;
		logic signed [47:0] bond_work;
	} out_t;

	localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] INT32_MIN = 32'h8000_0000;
	localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

	function automatic logic [63:0] isqrt64_f(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bit_v;
		rem   = v;
		res   = '0;
		bit_v = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// factors 2^(-2^-j), j = 1..FRAC_W, in Q0.32, by repeated floor square roots
	function automatic logic [FRAC_W*32-1:0] pow_tab_f();
		logic [FRAC_W*32-1:0] tab;
		logic [63:0]          c;
		tab = '0;
		c   = isqrt64_f(64'h8000_0000_0000_0000);
		for (int j = 0; j < FRAC_W; j++) begin
			tab[j*32 +: 32] = c[31:0];
			c = isqrt64_f({c[31:0], 32'd0});
		end
		return tab;
	endfunction

	localparam logic [FRAC_W*32-1:0] POW_TAB = pow_tab_f();

endpackage

/* design/bsmu_div.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
module bsmu_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bsmu_pkg::DIV_W-1:0]    dividend,
	input  logic [bsmu_pkg::DVSR_W-1:0]   divisor,
	output logic                          busy,
	output logic [bsmu_pkg::DIV_W-1:0]    quotient
);
	import bsmu_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVSR_W:0]   trial_w;
	logic              ge_w;
	logic [DVSR_W:0]   diff_w;

	assign trial_w = {rem_q, quo_q[DIV_W-1]};
	assign ge_w    = trial_w >= {1'b0, dvsr_q};
	assign diff_w  = trial_w - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(DIV_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge_w ? diff_w[DVSR_W-1:0] : trial_w[DVSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge_w};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* design/bsmu_dp.sv */
`timescale 1ns / 1ps
// Datapath: configuration, material state, shared multiplier and divider.
module bsmu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_idx,
	input  logic [30:0]        cfg_wdata,
	input  bsmu_pkg::in_t      in_data,
	input  bsmu_pkg::cmd_t     cmd,
	output bsmu_pkg::status_t  status,
	output bsmu_pkg::out_t     out_data
);
	import bsmu_pkg::*;

	// configuration
	logic [30:0] tau_max_q, tau_f_q, s0_q, s1_q, s2_q, s3_q, k0_q;
	logic [15:0] alpha_q;
	logic [30:0] bp0_w, bp1_w, bp2_w, bp3_w;

	// material state
	logic [31:0] cslip_q, cstress_q, cpeak_q, tslip_q, tstress_q, tpeak_q, ttan_q;
	logic [47:0] cwork_q, twork_q;

	// item working registers
	mode_t       mode_q;
	logic [31:0] s_q, b_q;
	logic        load_q;
	logic [31:0] m_q;
	logic [4:0]  lz_q;
	logic [23:0] frac_q;
	logic [33:0] ny_q;
	logic [32:0] res_q, p_q;
	logic [30:0] tau_q;
	logic [31:0] tan_q, ns_q, nt_q;
	logic [65:0] prod_q;
	out_t        out_q;

	logic [31:0] a_w;
	logic [32:0] mul_a, mul_b;
	logic        mul_en;
	logic        div_start, div_busy;
	logic [63:0] div_dvd, quo_w;
	logic [31:0] div_dvs;
	region_t     region_w;

	logic [31:0] d_w;
	logic [30:0] dmag_w, span_w, bx_w;
	logic [5:0]  lz1_w;
	logic [29:0] nl_w;
	logic [31:0] ctab_w;
	logic [23:0] nyf_w;
	logic [4:0]  nybit_w;
	logic [9:0]  q_w;
	logic [32:0] mm_w;
	logic [33:0] pk34_w, smp34_w, diff34_w, udabs34_w;
	logic        udneg_w;
	logic [32:0] udmag_w, sum33_w, ds33_w, sum_mag_w, ds_mag_w;
	logic [32:0] tsoft_w;
	logic [32:0] peak33_w;
	logic signed [64:0] sp65_w, sh65_w, uv65_w;
	logic [31:0] unl_w;
	logic [46:0] mag47_w;
	logic signed [49:0] w50_w;
	logic [47:0] wsat_w;
	logic        big_w;

	// break points, repaired for ill-ordered settings
	assign bp1_w = (s1_q == '0) ? 31'd1 : s1_q;
	assign bp0_w = (s0_q < bp1_w) ? s0_q : bp1_w;
	assign bp2_w = (s2_q > bp1_w) ? s2_q : bp1_w;
	assign bp3_w = (s3_q > bp2_w) ? s3_q : bp2_w;

	assign a_w = s_q[31] ? (~s_q + 32'd1) : s_q;

	always_comb begin
		if (b_q <= {1'b0, bp0_w})
			region_w = RG_LIN;
		else if (b_q <= {1'b0, bp1_w})
			region_w = RG_POW;
		else if (b_q <= {1'b0, bp2_w})
			region_w = RG_PLAT;
		else if (b_q <= {1'b0, bp3_w})
			region_w = RG_SOFT;
		else
			region_w = RG_RESID;
	end

	assign d_w    = {1'b0, tau_max_q} - {1'b0, tau_f_q};
	assign dmag_w = d_w[31] ? 31'(32'd0 - d_w) : d_w[30:0];
	assign span_w = bp3_w - bp2_w;
	assign bx_w   = b_q[30:0] - bp2_w;

	assign lz1_w   = {1'b0, lz_q} + 6'd1;
	assign nl_w    = {lz1_w, 24'd0} - {6'd0, frac_q};
	assign ctab_w  = POW_TAB[{cmd.idx, 5'd0} +: 32];
	assign nyf_w   = ny_q[23:0];
	assign nybit_w = 5'd23 - cmd.idx;
	assign q_w     = ny_q[33:24];
	assign mm_w    = prod_q[63:31];

	// unloading line through the committed peak point
	assign pk34_w    = {2'b0, cpeak_q};
	assign smp34_w   = cslip_q[31] ? (34'd0 - pk34_w) : pk34_w;
	assign diff34_w  = smp34_w - {{2{s_q[31]}}, s_q};
	assign udneg_w   = diff34_w[33];
	assign udabs34_w = udneg_w ? (34'd0 - diff34_w) : diff34_w;
	assign udmag_w   = udabs34_w[32:0];

	assign sum33_w   = {cstress_q[31], cstress_q} + {ns_q[31], ns_q};
	assign ds33_w    = {s_q[31], s_q} - {cslip_q[31], cslip_q};
	assign sum_mag_w = sum33_w[32] ? (33'd0 - sum33_w) : sum33_w;
	assign ds_mag_w  = ds33_w[32] ? (33'd0 - ds33_w) : ds33_w;

	assign tsoft_w = d_w[31] ? ({2'b0, tau_max_q} + {1'b0, quo_w[31:0]})
	                         : ({2'b0, tau_max_q} - {1'b0, quo_w[31:0]});

	assign peak33_w = cslip_q[31] ? (33'd0 - {2'b0, tau_q}) : {2'b0, tau_q};
	assign sp65_w   = udneg_w ? $signed(65'd0 - {1'b0, prod_q[63:0]})
	                          : $signed({1'b0, prod_q[63:0]});
	assign sh65_w   = sp65_w >>> 16;
	assign uv65_w   = $signed({{32{peak33_w[32]}}, peak33_w}) - sh65_w;

	always_comb begin
		if (uv65_w > 65'sd2147483647)
			unl_w = INT32_MAX;
		else if (uv65_w < -65'sd2147483648)
			unl_w = INT32_MIN;
		else
			unl_w = uv65_w[31:0];
	end

	assign mag47_w = prod_q[63:17];
	assign w50_w   = $signed(((sum33_w[32] != ds33_w[32]) ? (50'd0 - {3'b0, mag47_w})
	                                                      : {3'b0, mag47_w}))
	                 + $signed({{2{cwork_q[47]}}, cwork_q});

	always_comb begin
		if (w50_w > 50'sd140737488355327)
			wsat_w = 48'h7FFF_FFFF_FFFF;
		else if (w50_w < -50'sd140737488355328)
			wsat_w = 48'h8000_0000_0000;
		else
			wsat_w = w50_w[47:0];
	end

	assign big_w = |quo_w[63:31];

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			OP_MUL_LIN: begin
				mul_a = {2'b0, k0_q};
				mul_b = {1'b0, b_q};
			end
			OP_SQ_MUL: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			OP_NL_MUL: begin
				mul_a = {17'd0, alpha_q};
				mul_b = {3'd0, nl_w};
			end
			OP_EXP_MUL: begin
				mul_a = res_q;
				mul_b = {1'b0, ctab_w};
			end
			OP_TAU_MUL: begin
				mul_a = {2'b0, tau_max_q};
				mul_b = p_q;
			end
			OP_TANP_MUL: begin
				mul_a = {17'd0, alpha_q};
				mul_b = {2'b0, tau_q};
			end
			OP_SOFT_MUL: begin
				mul_a = {2'b0, dmag_w};
				mul_b = {2'b0, bx_w};
			end
			OP_UNL_MUL: begin
				mul_a = {2'b0, k0_q};
				mul_b = udmag_w;
			end
			OP_WORK_MUL: begin
				mul_a = sum_mag_w;
				mul_b = ds_mag_w;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// divider operand select
	always_comb begin
		div_start = 1'b1;
		div_dvd   = '0;
		div_dvs   = 32'd1;
		case (cmd.op)
			OP_DIV_X: begin
				div_dvd = {b_q, 32'd0};
				div_dvs = {1'b0, bp1_w};
			end
			OP_TANP_DIV: begin
				div_dvd = {prod_q[59:0], 4'd0};
				div_dvs = b_q;
			end
			OP_SOFT_DIV: begin
				div_dvd = prod_q[63:0];
				div_dvs = {1'b0, span_w};
			end
			OP_SOFT_DIV2: begin
				div_dvd = {17'd0, dmag_w, 16'd0};
				div_dvs = {1'b0, span_w};
			end
			default: div_start = 1'b0;
		endcase
	end

	bsmu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (quo_w)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_max_q <= '0;
			tau_f_q   <= '0;
			s0_q      <= 31'd6554;
			s1_q      <= 31'd65536;
			s2_q      <= 31'd65536;
			s3_q      <= 31'd65536;
			alpha_q   <= 16'd4096;
			k0_q      <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_PEAK_STRESS:  tau_max_q <= cfg_wdata;
				REG_RESID_STRESS: tau_f_q   <= cfg_wdata;
				REG_LIN_SLIP:     s0_q      <= cfg_wdata;
				REG_PEAK_SLIP:    s1_q      <= cfg_wdata;
				REG_PLAT_SLIP:    s2_q      <= cfg_wdata;
				REG_SOFT_SLIP:    s3_q      <= cfg_wdata;
				REG_EXPONENT:     alpha_q   <= cfg_wdata[15:0];
				REG_STIFFNESS:    k0_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// committed and trial state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cslip_q   <= '0;
			cstress_q <= '0;
			cpeak_q   <= '0;
			cwork_q   <= '0;
			tslip_q   <= '0;
			tstress_q <= '0;
			tpeak_q   <= '0;
			twork_q   <= '0;
			ttan_q    <= '0;
		end else begin
			case (cmd.op)
				OP_COMMIT: begin
					cslip_q   <= tslip_q;
					cstress_q <= tstress_q;
					cpeak_q   <= tpeak_q;
					cwork_q   <= twork_q;
				end
				OP_REVERT: begin
					tslip_q   <= cslip_q;
					tstress_q <= cstress_q;
					tpeak_q   <= cpeak_q;
					twork_q   <= cwork_q;
					ttan_q    <= {1'b0, k0_q};
				end
				OP_RESET: begin
					cslip_q   <= '0;
					cstress_q <= '0;
					cpeak_q   <= '0;
					cwork_q   <= '0;
					tslip_q   <= '0;
					tstress_q <= '0;
					tpeak_q   <= '0;
					twork_q   <= '0;
					ttan_q    <= {1'b0, k0_q};
				end
				OP_WORK_FIN: begin
					tslip_q   <= s_q;
					tstress_q <= ns_q;
					tpeak_q   <= load_q ? b_q : cpeak_q;
					twork_q   <= wsat_w;
					ttan_q    <= nt_q;
				end
				default: ;
			endcase
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= 66'(mul_a) * 66'(mul_b);
		case (cmd.op)
			OP_ACCEPT: begin
				mode_q <= mode_t'(in_data.mode);
				s_q    <= in_data.slip;
			end
			OP_SETUP: begin
				load_q <= a_w >= cpeak_q;
				b_q    <= (a_w >= cpeak_q) ? a_w : cpeak_q;
			end
			OP_LIN_FIN: begin
				tau_q <= (|prod_q[62:47]) ? 31'h7FFF_FFFF : prod_q[46:16];
				tan_q <= {1'b0, k0_q};
			end
			OP_POW_ONE: p_q <= {1'b1, 32'd0};
			OP_NORM_LOAD: begin
				m_q    <= quo_w[31:0];
				lz_q   <= '0;
				frac_q <= '0;
			end
			OP_NORM_SHIFT: begin
				m_q  <= {m_q[30:0], 1'b0};
				lz_q <= lz_q + 5'd1;
			end
			OP_SQ_ADJ: begin
				if (mm_w[32]) begin
					frac_q <= {frac_q[22:0], 1'b1};
					m_q    <= mm_w[32:1];
				end else begin
					frac_q <= {frac_q[22:0], 1'b0};
					m_q    <= mm_w[31:0];
				end
			end
			OP_NY_LATCH: begin
				ny_q  <= prod_q[45:12];
				res_q <= {1'b1, 32'd0};
			end
			OP_EXP_UPD: begin
				if (nyf_w[nybit_w])
					res_q <= prod_q[64:32];
			end
			OP_P_FIN: p_q <= (q_w >= 10'd33) ? 33'd0 : (res_q >> q_w[5:0]);
			OP_TAU_FIN: tau_q <= prod_q[62:32];
			OP_TANP_FIN: begin
				if (quo_w == '0)
					tan_q <= {1'b0, k0_q};
				else if (big_w)
					tan_q <= INT32_MAX;
				else
					tan_q <= quo_w[31:0];
			end
			OP_PLAT: begin
				tau_q <= tau_max_q;
				tan_q <= {1'b0, k0_q};
			end
			OP_SOFT_TAU: tau_q <= tsoft_w[30:0];
			OP_SOFT_FIN: begin
				// a zero slope past the plateau reads as -1 LSB
				if (quo_w == '0)
					tan_q <= MINUS_ONE;
				else if (!d_w[31])
					tan_q <= big_w ? INT32_MIN : (32'd0 - quo_w[31:0]);
				else
					tan_q <= big_w ? INT32_MAX : quo_w[31:0];
			end
			OP_RESID: begin
				tau_q <= tau_f_q;
				tan_q <= MINUS_ONE;
			end
			OP_STRESS: begin
				if (load_q) begin
					ns_q <= s_q[31] ? (32'd0 - {1'b0, tau_q}) : {1'b0, tau_q};
					nt_q <= tan_q;
				end else begin
					ns_q <= unl_w;
					nt_q <= {1'b0, k0_q};
				end
			end
			OP_OUT_LOAD: begin
				out_q.bond_stress <= tstress_q;
				out_q.tangent     <= ttan_q;
				out_q.bond_work   <= twork_q;
			end
			default: ;
		endcase
	end

	assign status.mode      = mode_q;
	assign status.region    = region_w;
	assign status.x_ge_one  = |quo_w[63:32];
	assign status.norm_done = m_q[31];
	assign status.div_busy  = div_busy;
	assign out_data         = out_q;

endmodule

/* design/bsmu_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences one item through the datapath and runs the handshakes.
module bsmu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bsmu_pkg::status_t   status,
	output bsmu_pkg::cmd_t      cmd
);
	import bsmu_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE, ST_DISPATCH, ST_CLASSIFY,
		ST_LIN_MUL, ST_LIN_FIN,
		ST_X_DIV, ST_X_WAIT, ST_X_CHK, ST_NORM,
		ST_SQ_MUL, ST_SQ_ADJ, ST_NL_MUL, ST_NY,
		ST_EXP_MUL, ST_EXP_UPD, ST_P_FIN,
		ST_TAU_MUL, ST_TAU_FIN, ST_TANP_MUL, ST_TANP_DIV, ST_TANP_WAIT, ST_TANP_FIN,
		ST_PLAT,
		ST_SOFT_MUL, ST_SOFT_DIV, ST_SOFT_WAIT, ST_SOFT_TAU,
		ST_SOFT_DIV2, ST_SOFT_WAIT2, ST_SOFT_FIN,
		ST_RESID,
		ST_UNL_MUL, ST_STRESS, ST_WORK_MUL, ST_WORK_FIN, ST_OUTPUT
	} state_t;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_W - 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op  = OP_NOP;
		cmd.idx = cnt_q;
		case (state_q)
			ST_IDLE:      if (in_valid) cmd.op = OP_ACCEPT;
			ST_DISPATCH: begin
				case (status.mode)
					MODE_TRIAL:  cmd.op = OP_SETUP;
					MODE_COMMIT: cmd.op = OP_COMMIT;
					MODE_REVERT: cmd.op = OP_REVERT;
					default:     cmd.op = OP_RESET;
				endcase
			end
			ST_LIN_MUL:   cmd.op = OP_MUL_LIN;
			ST_LIN_FIN:   cmd.op = OP_LIN_FIN;
			ST_X_DIV:     cmd.op = OP_DIV_X;
			ST_X_CHK:     cmd.op = status.x_ge_one ? OP_POW_ONE : OP_NORM_LOAD;
			ST_NORM:      if (!status.norm_done) cmd.op = OP_NORM_SHIFT;
			ST_SQ_MUL:    cmd.op = OP_SQ_MUL;
			ST_SQ_ADJ:    cmd.op = OP_SQ_ADJ;
			ST_NL_MUL:    cmd.op = OP_NL_MUL;
			ST_NY:        cmd.op = OP_NY_LATCH;
			ST_EXP_MUL:   cmd.op = OP_EXP_MUL;
			ST_EXP_UPD:   cmd.op = OP_EXP_UPD;
			ST_P_FIN:     cmd.op = OP_P_FIN;
			ST_TAU_MUL:   cmd.op = OP_TAU_MUL;
			ST_TAU_FIN:   cmd.op = OP_TAU_FIN;
			ST_TANP_MUL:  cmd.op = OP_TANP_MUL;
			ST_TANP_DIV:  cmd.op = OP_TANP_DIV;
			ST_TANP_FIN:  cmd.op = OP_TANP_FIN;
			ST_PLAT:      cmd.op = OP_PLAT;
			ST_SOFT_MUL:  cmd.op = OP_SOFT_MUL;
			ST_SOFT_DIV:  cmd.op = OP_SOFT_DIV;
			ST_SOFT_TAU:  cmd.op = OP_SOFT_TAU;
			ST_SOFT_DIV2: cmd.op = OP_SOFT_DIV2;
			ST_SOFT_FIN:  cmd.op = OP_SOFT_FIN;
			ST_RESID:     cmd.op = OP_RESID;
			ST_UNL_MUL:   cmd.op = OP_UNL_MUL;
			ST_STRESS:    cmd.op = OP_STRESS;
			ST_WORK_MUL:  cmd.op = OP_WORK_MUL;
			ST_WORK_FIN:  cmd.op = OP_WORK_FIN;
			ST_OUTPUT:    if (out_free) cmd.op = OP_OUT_LOAD;
			default:      cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:     if (in_valid) state_q <= ST_DISPATCH;
				ST_DISPATCH: state_q <= (status.mode == MODE_TRIAL) ? ST_CLASSIFY : ST_OUTPUT;
				ST_CLASSIFY: begin
					case (status.region)
						RG_LIN:  state_q <= ST_LIN_MUL;
						RG_POW:  state_q <= ST_X_DIV;
						RG_PLAT: state_q <= ST_PLAT;
						RG_SOFT: state_q <= ST_SOFT_MUL;
						default: state_q <= ST_RESID;
					endcase
				end
				ST_LIN_MUL:  state_q <= ST_LIN_FIN;
				ST_LIN_FIN:  state_q <= ST_UNL_MUL;
				ST_X_DIV:    state_q <= ST_X_WAIT;
				ST_X_WAIT:   if (!status.div_busy) state_q <= ST_X_CHK;
				ST_X_CHK:    state_q <= status.x_ge_one ? ST_TAU_MUL : ST_NORM;
				ST_NORM: begin
					if (status.norm_done) begin
						cnt_q   <= '0;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQ_MUL:   state_q <= ST_SQ_ADJ;
				ST_SQ_ADJ: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == LAST_STEP) ? ST_NL_MUL : ST_SQ_MUL;
				end
				ST_NL_MUL:   state_q <= ST_NY;
				ST_NY: begin
					cnt_q   <= '0;
					state_q <= ST_EXP_MUL;
				end
				ST_EXP_MUL:  state_q <= ST_EXP_UPD;
				ST_EXP_UPD: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == LAST_STEP) ? ST_P_FIN : ST_EXP_MUL;
				end
				ST_P_FIN:     state_q <= ST_TAU_MUL;
				ST_TAU_MUL:   state_q <= ST_TAU_FIN;
				ST_TAU_FIN:   state_q <= ST_TANP_MUL;
				ST_TANP_MUL:  state_q <= ST_TANP_DIV;
				ST_TANP_DIV:  state_q <= ST_TANP_WAIT;
				ST_TANP_WAIT: if (!status.div_busy) state_q <= ST_TANP_FIN;
				ST_TANP_FIN:  state_q <= ST_UNL_MUL;
				ST_PLAT:      state_q <= ST_UNL_MUL;
				ST_SOFT_MUL:  state_q <= ST_SOFT_DIV;
				ST_SOFT_DIV:  state_q <= ST_SOFT_WAIT;
				ST_SOFT_WAIT: if (!status.div_busy) state_q <= ST_SOFT_TAU;
				ST_SOFT_TAU:  state_q <= ST_SOFT_DIV2;
				ST_SOFT_DIV2: state_q <= ST_SOFT_WAIT2;
				ST_SOFT_WAIT2: if (!status.div_busy) state_q <= ST_SOFT_FIN;
				ST_SOFT_FIN:  state_q <= ST_UNL_MUL;
				ST_RESID:     state_q <= ST_UNL_MUL;
				ST_UNL_MUL:   state_q <= ST_STRESS;
				ST_STRESS:    state_q <= ST_WORK_MUL;
				ST_WORK_MUL:  state_q <= ST_WORK_FIN;
				ST_WORK_FIN:  state_q <= ST_OUTPUT;
				ST_OUTPUT: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* design/bond_slip_material_update.sv */
`timescale 1ns / 1ps
// Top level of the bond-slip material update block.
//
// One item is worked at a time; each gives one result beat. Commit, revert and reset
// items skip the law and go from dispatch straight to the output. The time of a trial is
// set by the one radix-2 divider (one division on the power law for the slip ratio and
// one for its tangent, two on softening), by the 24 squaring steps of log2 and the 24
// factor steps of exp2 on the single shared 33x33 multiplier, and by one-bit
// normalization. A new item is accepted while a finished result still waits in the
// output register.
module bond_slip_material_update (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bsmu_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output bsmu_pkg::out_t  out_data,
	input  logic            cfg_wen,
	input  logic [2:0]      cfg_idx,
	input  logic [30:0]     cfg_wdata
);
	import bsmu_pkg::*;

	cmd_t    cmd;
	status_t status;

	bsmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bsmu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted beat did not leave idle");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result loaded without returning to idle");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !status.div_busy)
		else $error("divider still busy while idle");
`endif

endmodule

/* bench/tb_bond_slip_material_update.sv */
`timescale 1ns / 1ps
// Testbench for the bond-slip material update block: random and directed items checked
// against a fixed-point model of the bond-slip law.
module tb_bond_slip_material_update;
	import bsmu_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam longint WORK_HI = 64'sd140737488355327;
	localparam longint WORK_LO = -64'sd140737488355328;

	// ---------------------------------------------------------------- material model
	class bond_law_scoreboard;
		bit [30:0] tau_max, tau_res, s0_reg, s1_reg, s2_reg, s3_reg, k0;
		bit [15:0] alpha;
		longint c_slip, c_stress, c_work, t_slip, t_stress, t_work, t_tan;
		bit [31:0] c_peak, t_peak;
		bit [31:0] e0, e1, e2, e3;
		bit [31:0] exp_fac[24];
		out_t stress_queue[$];
		int errors;

		function void init();
			bit [63:0] c;
			tau_max = 0; tau_res = 0; s0_reg = 6554; s1_reg = 65536;
			s2_reg = 65536; s3_reg = 65536; alpha = 4096; k0 = 0;
			clear_state();
			errors = 0;
			c = isqrt(64'h8000_0000_0000_0000);
			for (int j = 0; j < 24; j++) begin
				exp_fac[j] = c[31:0];
				c = isqrt({c[31:0], 32'd0});
			end
		endfunction

		function void clear_state();
			c_slip = 0; c_stress = 0; c_work = 0; c_peak = 0;
			t_slip = 0; t_stress = 0; t_work = 0; t_peak = 0; t_tan = k0;
		endfunction

		function bit [63:0] isqrt(bit [63:0] v);
			bit [63:0] res, b;
			res = 0; b = 64'h4000_0000_0000_0000;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b; res = (res >> 1) + b;
				end else res >>= 1;
				b >>= 2;
			end
			return res;
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void write_reg(reg_idx_t idx, bit [30:0] v);
			case (idx)
				REG_PEAK_STRESS: tau_max = v;
				REG_RESID_STRESS: tau_res = v;
				REG_LIN_SLIP: s0_reg = v;
				REG_PEAK_SLIP: s1_reg = v;
				REG_PLAT_SLIP: s2_reg = v;
				REG_SOFT_SLIP: s3_reg = v;
				REG_EXPONENT: alpha = v[15:0];
				REG_STIFFNESS: k0 = v;
				default: ;
			endcase
		endfunction

		function bit [63:0] power_ratio(bit [31:0] a);
			bit [63:0] x, m, frac, nl, ny, res;
			int p, q;
			x = {a, 32'd0} / e1;
			if (x >= 64'h1_0000_0000) return 64'h1_0000_0000;
			p = 0;
			while ((x >> (p + 1)) != 0) p++;
			m = x << (31 - p);
			frac = 0;
			for (int i = 0; i < 24; i++) begin
				m = (m * m) >> 31;
				frac <<= 1;
				if (m >= 64'h1_0000_0000) begin
					frac |= 1; m >>= 1;
				end
			end
			nl = (64'(32 - p) << 24) - frac;
			ny = (64'(alpha) * nl) >> 12;
			q = int'(ny >> 24);
			res = 64'h1_0000_0000;
			for (int i = 1; i <= 24; i++)
				if (ny[24 - i]) res = (res * exp_fac[i - 1]) >> 32;
			if (q >= 33) return 0;
			return res >> q;
		endfunction

		function longint envelope(bit [31:0] a, output longint tan);
			longint tau, t, d, span;
			bit [63:0] v;
			d = longint'(tau_max) - longint'(tau_res);
			if (a <= e0) begin
				v = (64'(k0) * a) >> 16;
				tau = v > 64'h7FFF_FFFF ? 64'sd2147483647 : longint'(v);
				t = k0;
			end else if (a <= e1) begin
				v = (64'(tau_max) * power_ratio(a)) >> 32;
				tau = longint'(v);
				t = sat32(longint'((64'(alpha) * v * 16) / a));
			end else if (a <= e2) begin
				tau = tau_max; t = 0;
			end else if (a <= e3) begin
				span = longint'(e3) - longint'(e2);
				tau = longint'(tau_max) - (d * (longint'(a) - longint'(e2))) / span;
				t = sat32(-(d * 65536) / span);
			end else begin
				tau = tau_res; t = 0;
			end
			if (t == 0) t = (a <= e2) ? longint'(k0) : -1;
			tan = t;
			return tau;
		endfunction

		function void trial_slip_update(longint s);
			bit [31:0] a;
			longint sgn, sm, tan, pk, prod, sum, ds, w;
			bit [63:0] mag;
			a = 32'(s < 0 ? -s : s);
			sgn = s >= 0 ? 1 : -1;
			e1 = s1_reg != 0 ? s1_reg : 1;
			e0 = s0_reg < e1 ? s0_reg : e1;
			e2 = s2_reg > e1 ? s2_reg : e1;
			e3 = s3_reg > e2 ? s3_reg : e2;
			t_slip = s;
			if (a >= c_peak) begin
				t_peak = a;
				t_stress = sgn * envelope(a, tan);
				t_tan = tan;
			end else begin
				sm = c_slip >= 0 ? 1 : -1;
				t_peak = c_peak;
				pk = sm * envelope(c_peak, tan);
				prod = longint'(k0) * (sm * longint'(c_peak) - s);
				t_stress = sat32(pk - (prod >>> 16));
				t_tan = k0;
			end
			sum = c_stress + t_stress;
			ds = s - c_slip;
			mag = (64'(sum < 0 ? -sum : sum) * 64'(ds < 0 ? -ds : ds)) >> 17;
			w = ((sum < 0) != (ds < 0)) ? -longint'(mag) : longint'(mag);
			w += c_work;
			if (w > WORK_HI) w = WORK_HI;
			if (w < WORK_LO) w = WORK_LO;
			t_work = w;
		endfunction

		function void note_input(in_t beat);
			out_t r;
			case (mode_t'(beat.mode))
				MODE_TRIAL: trial_slip_update(longint'(beat.slip));
				MODE_COMMIT: begin
					c_slip = t_slip; c_stress = t_stress; c_peak = t_peak; c_work = t_work;
				end
				MODE_REVERT: begin
					t_slip = c_slip; t_stress = c_stress; t_peak = c_peak; t_work = c_work;
					t_tan = k0;
				end
				MODE_RESET: clear_state();
				default: ;
			endcase
			r.bond_stress = t_stress[31:0];
			r.tangent = t_tan[31:0];
			r.bond_work = t_work[47:0];
			stress_queue.push_back(r);
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (stress_queue.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			want = stress_queue.pop_front();
			if (got.bond_stress !== want.bond_stress) begin
				$error("bond_stress: expected %0d, got %0d", want.bond_stress, got.bond_stress);
				errors++;
			end
			if (got.tangent !== want.tangent) begin
				$error("tangent: expected %0d, got %0d", want.tangent, got.tangent);
				errors++;
			end
			if (got.bond_work !== want.bond_work) begin
				$error("bond_work: expected %0d, got %0d", want.bond_work, got.bond_work);
				errors++;
			end
		endfunction
	endclass

	// ---------------------------------------------------------------- signals
	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_t in_data;
	out_t out_data;
	logic cfg_wen;
	logic [2:0] cfg_idx;
	logic [30:0] cfg_wdata;

	bond_law_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	int idle_cycles;

	bond_slip_material_update uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random stall, check every accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// valid stays up after the accept; the next beat, an idle cycle or a drain drops it
	task automatic send_item(mode_t m, logic signed [31:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{mode: m, slip: s};
		do @(posedge clk); while (!in_ready);
		sb.note_input(in_data);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.stress_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write enable stays up across a burst of writes; the caller drops it
	task automatic write_cfg(reg_idx_t idx, logic [30:0] v);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	// random slip of random sign, drawn from one of four fixed ranges
	function automatic logic signed [31:0] rand_slip(int span_sel);
		logic signed [31:0] v;
		case (span_sel)
			0: v = $urandom_range(200000);
			1: v = $urandom_range(3000000);
			2: v = $urandom();
			default: v = $urandom_range(40000);
		endcase
		if ($urandom_range(1)) v = -v;
		return v;
	endfunction

	task automatic random_phase(int count);
		mode_t m;
		int r, span_sel;
		span_sel = $urandom_range(3);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			m = r < 70 ? MODE_TRIAL : r < 88 ? MODE_COMMIT : r < 96 ? MODE_REVERT : MODE_RESET;
			send_item(m, $urandom_range(9) == 0 ? $urandom() : rand_slip(span_sel));
		end
	endtask

	task automatic random_config(int sel);
		logic [30:0] s1v;
		s1v = sel == 0 ? 31'd65536 : 31'($urandom_range(1, 200000));
		write_cfg(REG_PEAK_STRESS, sel == 1 ? 31'h7FFF_FFFF : 31'($urandom_range(2000000)));
		write_cfg(REG_RESID_STRESS, sel == 2 ? 31'd0 : 31'($urandom_range(3000000)));
		write_cfg(REG_LIN_SLIP, 31'($urandom_range(s1v)));
		write_cfg(REG_PEAK_SLIP, s1v);
		write_cfg(REG_PLAT_SLIP, 31'(s1v + $urandom_range(100000)));
		write_cfg(REG_SOFT_SLIP, sel == 3 ? 31'd1 : 31'(s1v + $urandom_range(2000000)));
		write_cfg(REG_EXPONENT, sel == 1 ? 31'd65535 : 31'($urandom_range(8192)));
		write_cfg(REG_STIFFNESS, sel == 1 ? 31'h7FFF_FFFF : 31'($urandom_range(3000000)));
		cfg_wen <= 1'b0;
	endtask

	initial begin
		sb = new();
		sb.init();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = REG_PEAK_STRESS;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers first, then a typical law
		send_item(MODE_TRIAL, 32'sd70000);
		send_item(MODE_TRIAL, 32'sh8000_0000);
		drain();
		write_cfg(REG_PEAK_STRESS, 31'd655360);
		write_cfg(REG_RESID_STRESS, 31'd131072);
		write_cfg(REG_LIN_SLIP, 31'd6554);
		write_cfg(REG_PEAK_SLIP, 31'd65536);
		write_cfg(REG_PLAT_SLIP, 31'd131072);
		write_cfg(REG_SOFT_SLIP, 31'd327680);
		write_cfg(REG_EXPONENT, 31'd1638);
		write_cfg(REG_STIFFNESS, 31'd6553600);
		cfg_wen <= 1'b0;
		// directed: each branch, unloading both ways, every mode, slip extremes
		send_item(MODE_TRIAL, 32'sd0);
		send_item(MODE_TRIAL, 32'sd3000);
		send_item(MODE_TRIAL, 32'sd30000);
		send_item(MODE_TRIAL, 32'sd65536);
		send_item(MODE_TRIAL, -32'sd100000);
		send_item(MODE_COMMIT, 32'sd0);
		send_item(MODE_TRIAL, -32'sd20000);
		send_item(MODE_TRIAL, 32'sd20000);
		send_item(MODE_REVERT, 32'sd0);
		send_item(MODE_TRIAL, 32'sd200000);
		send_item(MODE_COMMIT, 32'sd0);
		send_item(MODE_TRIAL, 32'sd1000);
		send_item(MODE_TRIAL, 32'sd400000);
		send_item(MODE_TRIAL, 32'sh7FFF_FFFF);
		send_item(MODE_COMMIT, 32'sd0);
		send_item(MODE_TRIAL, -32'sd1);
		send_item(MODE_RESET, 32'sh7FFF_FFFF);
		send_item(MODE_TRIAL, 32'sh8000_0000);
		// residual above peak stress: softening rises
		drain();
		write_cfg(REG_RESID_STRESS, 31'd900000);
		cfg_wen <= 1'b0;
		send_item(MODE_TRIAL, 32'sd250000);
		send_item(MODE_TRIAL, -32'sd250000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			random_config(ph % 5);
			send_item(MODE_RESET, $urandom());
			random_phase(67);
			// hold until every expected result is back
			in_valid <= 1'b0;
			while (sb.stress_queue.size() != 0) @(posedge clk);
			random_phase(67);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.stress_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			if (sb.stress_queue.size() != 0) $error("%0d results never came", sb.stress_queue.size());
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
